FILE: sv/npp_pkg.sv
// Shared types and constants for the NAT port pool.
`default_nettype none
package npp_pkg;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic REG_FIRST_PORT  = 1'b0;
    localparam logic REG_PROBE_LIMIT = 1'b1;

    localparam logic [15:0] FIRST_PORT_RST  = 16'd1024;
    localparam logic [10:0] PROBE_LIMIT_RST = 11'd256;

    typedef struct packed {
        logic [15:0] first_port;
        logic [10:0] probe_limit;
    } npp_cfg_t;

    // Advance a cursor by one, wrapping, and raise it to first_port.
    function automatic logic [15:0] cursor_step(input logic [15:0] cur,
                                                input logic [15:0] first_port);
        logic [15:0] c;
        c = cur + 16'd1;
        if (c < first_port)
            c = first_port;
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: sv/npp_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module npp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

FILE: sv/npp_ctrl.sv
// Sequencer for allocate and release: host table and port owner memories.
`default_nettype none
module npp_ctrl import npp_pkg::*; #(
    parameter int HOST_INDEX_BITS = 12,
    parameter int SLOT_BITS       = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire npp_cfg_t    cfg,
    input  wire logic        start,
    input  wire logic        func,
    input  wire logic [31:0] ip,
    input  wire logic [15:0] port,
    input  wire logic [1:0]  proto,
    output logic             busy,
    output logic             done,
    output logic [1:0]       status,
    output logic [15:0]      port_out
);

    localparam int OWN_AW   = 17 + SLOT_BITS;
    localparam int CLR_BITS = (OWN_AW > HOST_INDEX_BITS) ? OWN_AW : HOST_INDEX_BITS;
    localparam int HOST_W   = 64;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_REL   = 3'd2;
    localparam logic [2:0] S_HOST  = 3'd3;
    localparam logic [2:0] S_PROBE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CLR_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0]         ip_reg, ip_next;
    logic [15:0]         port_reg, port_next;
    logic                proto_reg, proto_next;
    logic [15:0]         cur_reg, cur_next;
    logic [15:0]         other_reg, other_next;
    logic [10:0]         n_reg, n_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [15:0]         port_out_reg, port_out_next;

    logic                       host_we;
    logic [HOST_INDEX_BITS-1:0] host_addr;
    logic [HOST_W-1:0]          host_wdata, host_rdata;
    logic                       own_we;
    logic [OWN_AW-1:0]          own_addr;
    logic [31:0]                own_wdata, own_rdata;

    logic                 a_proto;
    logic [15:0]          a_port;
    logic [SLOT_BITS-1:0] a_slot;
    logic [15:0]          wb_cur, wb_other, sel_cur, sel_other, step_c;
    logic [31:0]          host_owner;

    npp_ram #(.WIDTH(HOST_W), .DEPTH(2 ** HOST_INDEX_BITS)) u_host_ram (
        .clk   (clk),
        .we    (host_we),
        .addr  (host_addr),
        .wdata (host_wdata),
        .rdata (host_rdata)
    );

    npp_ram #(.WIDTH(32), .DEPTH(2 ** OWN_AW)) u_own_ram (
        .clk   (clk),
        .we    (own_we),
        .addr  (own_addr),
        .wdata (own_wdata),
        .rdata (own_rdata)
    );

    assign host_owner = host_rdata[31:0];
    assign sel_cur    = proto_reg ? host_rdata[63:48] : host_rdata[47:32];
    assign sel_other  = proto_reg ? host_rdata[47:32] : host_rdata[63:48];

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        ip_next       = ip_reg;
        port_next     = port_reg;
        proto_next    = proto_reg;
        cur_next      = cur_reg;
        other_next    = other_reg;
        n_next        = n_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        port_out_next = port_out_reg;

        host_we   = 1'b0;
        host_addr = ip_reg[8 +: HOST_INDEX_BITS];
        wb_cur    = cur_reg;
        wb_other  = other_reg;
        own_we    = 1'b0;
        own_wdata = 32'd0;
        a_proto   = proto_reg;
        a_port    = port_reg;
        a_slot    = ip_reg[31 -: SLOT_BITS];
        step_c    = cursor_step(cur_reg, cfg.first_port);

        case (state_reg)
            S_CLEAR:
            begin
                host_we   = 1'b1;
                own_we    = 1'b1;
                wb_cur    = 16'd0;
                wb_other  = 16'd0;
                host_addr = clr_cnt_reg[HOST_INDEX_BITS-1:0];
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                a_proto   = proto[0];
                a_port    = port;
                a_slot    = ip[31 -: SLOT_BITS];
                host_addr = ip[8 +: HOST_INDEX_BITS];
                if (start)
                begin
                    ip_next    = ip;
                    port_next  = port;
                    proto_next = proto[0];
                    if (proto[1] || ip == 32'd0)
                    begin
                        done_next     = 1'b1;
                        status_next   = ST_INVALID;
                        port_out_next = 16'd0;
                    end
                    else if (func == FUNC_RELEASE)
                        state_next = S_REL;
                    else
                        state_next = S_HOST;
                end
            end
            S_REL:
            begin
                done_next     = 1'b1;
                port_out_next = 16'd0;
                state_next    = S_IDLE;
                if (own_rdata == ip_reg)
                begin
                    own_we      = 1'b1;
                    status_next = ST_OK;
                end
                else
                    status_next = ST_NONE;
            end
            S_HOST:
            begin
                if (host_owner == ip_reg || host_owner == 32'd0)
                begin
                    cur_next   = sel_cur;
                    other_next = sel_other;
                    if (cfg.probe_limit == 11'd0)
                    begin
                        // Claim the entry, leave cursors as read.
                        host_we       = 1'b1;
                        wb_cur        = sel_cur;
                        wb_other      = sel_other;
                        done_next     = 1'b1;
                        status_next   = ST_NONE;
                        port_out_next = 16'd0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        step_c     = cursor_step(sel_cur, cfg.first_port);
                        cur_next   = step_c;
                        a_port     = step_c;
                        n_next     = 11'd1;
                        state_next = S_PROBE;
                    end
                end
                else
                begin
                    done_next     = 1'b1;
                    status_next   = ST_NONE;
                    port_out_next = 16'd0;
                    state_next    = S_IDLE;
                end
            end
            S_PROBE:
            begin
                a_port = cur_reg;
                if (own_rdata == 32'd0)
                begin
                    own_we        = 1'b1;
                    own_wdata     = ip_reg;
                    host_we       = 1'b1;
                    done_next     = 1'b1;
                    status_next   = ST_OK;
                    port_out_next = cur_reg;
                    state_next    = S_IDLE;
                end
                else if (n_reg == cfg.probe_limit)
                begin
                    host_we       = 1'b1;
                    done_next     = 1'b1;
                    status_next   = ST_NONE;
                    port_out_next = 16'd0;
                    state_next    = S_IDLE;
                end
                else
                begin
                    // Advance to the next port and probe it.
                    cur_next = step_c;
                    a_port   = step_c;
                    n_next   = n_reg + 11'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_CLEAR)
        begin
            own_addr   = clr_cnt_reg[OWN_AW-1:0];
            host_wdata = {HOST_W{1'b0}};
        end
        else
        begin
            own_addr   = {a_proto, a_port, a_slot};
            host_wdata = proto_reg ? {wb_cur, wb_other, ip_reg} : {wb_other, wb_cur, ip_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg       <= ip_next;
        port_reg     <= port_next;
        proto_reg    <= proto_next;
        cur_reg      <= cur_next;
        other_reg    <= other_next;
        n_reg        <= n_next;
        status_reg   <= status_next;
        port_out_reg <= port_out_next;
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign port_out = port_out_reg;

    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(start || state_reg == S_REL || state_reg == S_HOST
                           || state_reg == S_PROBE))
        else $error("result without a request");

    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (n_reg != 11'd0 && n_reg <= cfg.probe_limit))
        else $error("probe count out of range");

    a_port_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != ST_OK) |-> (port_out_reg == 16'd0))
        else $error("nonzero port on failed request");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!own_we && !host_we))
        else $error("memory write while idle");

endmodule
`default_nettype wire

FILE: sv/nat_port_pool_top.sv
// Top level: configuration registers and port pool sequencer.
// Path to done: an invalid request is answered from idle; release, refused host or zero
// probe limit pass S_REL or S_HOST; allocation passes S_HOST, then S_PROBE, one owner memory read per probe.
// One request at a time: busy drops as done rises.
// Reset starts a clearing pass that zeroes both memories, busy high.
// The done strobe lasts one cycle and cannot be stalled.
`default_nettype none
module nat_port_pool_top import npp_pkg::*; #(
    parameter int HOST_INDEX_BITS = 12,
    parameter int SLOT_BITS       = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    input  wire logic        func,
    input  wire logic [31:0] ip,
    input  wire logic [15:0] port,
    input  wire logic [1:0]  proto,
    output logic             busy,
    output logic             done,
    output logic [1:0]       status,
    output logic [15:0]      port_out
);

    logic [15:0] first_port_reg;
    logic [10:0] probe_limit_reg;
    logic        wr_xfer;
    npp_cfg_t    cfg;

    assign pready  = 1'b1;
    assign wr_xfer = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_port_reg  <= FIRST_PORT_RST;
            probe_limit_reg <= PROBE_LIMIT_RST;
        end
        else if (wr_xfer)
        begin
            if (paddr[2] == REG_FIRST_PORT)
                first_port_reg <= pwdata[15:0];
            else
                probe_limit_reg <= pwdata[10:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PROBE_LIMIT)
            prdata = {21'd0, probe_limit_reg};
        else
            prdata = {16'd0, first_port_reg};
    end

    assign cfg.first_port  = first_port_reg;
    assign cfg.probe_limit = probe_limit_reg;

    npp_ctrl #(
        .HOST_INDEX_BITS (HOST_INDEX_BITS),
        .SLOT_BITS       (SLOT_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .start    (start),
        .func     (func),
        .ip       (ip),
        .port     (port),
        .proto    (proto),
        .busy     (busy),
        .done     (done),
        .status   (status),
        .port_out (port_out)
    );

endmodule
`default_nettype wire

FILE: tb/tb_nat_port_pool_top.sv
// Testbench for nat_port_pool_top: directed table, then random traffic against a predictor.
`timescale 1ns / 1ps
module tb_nat_port_pool_top;
    import npp_pkg::*;

    localparam int HOST_BITS = 12;
    localparam int SLOT_W = 4;
    localparam int WATCHDOG_LIMIT = 1 << 24;
    localparam int SEG_ITEMS = 175;
    localparam int POOL_SIZE = 20;

    localparam logic [31:0] IP_A = 32'h0A00_0001;
    localparam logic [31:0] IP_B = 32'h0A00_0002;
    localparam logic [31:0] IP_C = 32'h0A00_0101;
    localparam logic [31:0] IP_D = 32'h0B00_0201;
    localparam logic [31:0] IP_E = 32'h0B00_0202;
    localparam logic [31:0] IP_MAX = 32'hFFFF_FFFF;
    localparam logic [1:0] PR_TCP = 2'd0;
    localparam logic [1:0] PR_UDP = 2'd1;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        fn;
        logic [31:0] addr;
        logic [15:0] prt;
        logic [1:0]  pr;
        logic        chk;
        logic [1:0]  st;
        logic [15:0] po;
        logic        reg_sel;
        logic [31:0] reg_val;
    } row_t;

    typedef struct {
        logic [1:0]  st;
        logic [15:0] po;
    } result_t;

    typedef struct {
        logic        pr;
        logic [15:0] prt;
        logic [31:0] addr;
    } lease_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        func;
    logic [31:0] ip;
    logic [15:0] port;
    logic [1:0]  proto;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [15:0] port_out;

    // predictor state
    logic [31:0] host_ip_tab [1 << HOST_BITS];
    logic [15:0] tcp_next [1 << HOST_BITS];
    logic [15:0] udp_next [1 << HOST_BITS];
    logic [31:0] port_taken [int unsigned];
    logic [15:0] cfg_first_port;
    logic [10:0] cfg_probe_limit;

    result_t     pending_results[$];
    lease_t      held_ports[$];
    logic [31:0] host_pool [POOL_SIZE];
    int          idle_pct;
    int          fail_cnt;
    int          quiet_cycles;

    nat_port_pool_top #(
        .HOST_INDEX_BITS(HOST_BITS),
        .SLOT_BITS(SLOT_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .func(func),
        .ip(ip),
        .port(port),
        .proto(proto),
        .busy(busy),
        .done(done),
        .status(status),
        .port_out(port_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic row_t item_row(input logic fn, input logic [31:0] addr,
                                      input logic [15:0] prt, input logic [1:0] pr);
        row_t r;
        r = '{kind: ROW_ITEM, fn: fn, addr: addr, prt: prt, pr: pr, chk: 1'b0,
              st: ST_OK, po: '0, reg_sel: REG_FIRST_PORT, reg_val: '0};
        return r;
    endfunction

    function automatic row_t chk_row(input logic fn, input logic [31:0] addr,
                                     input logic [15:0] prt, input logic [1:0] pr,
                                     input logic [1:0] st, input logic [15:0] po);
        row_t r;
        r = item_row(fn, addr, prt, pr);
        r.chk = 1'b1;
        r.st = st;
        r.po = po;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic sel, input logic [31:0] val);
        row_t r;
        r = item_row(FUNC_ALLOC, '0, '0, PR_TCP);
        r.kind = ROW_CFG;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    // Work out the result of one request and update the pool state.
    function automatic result_t pool_predict(input logic fn, input logic [31:0] addr,
                                             input logic [15:0] prt, input logic [1:0] pr);
        result_t res;
        logic [HOST_BITS-1:0] h;
        logic [SLOT_W-1:0] slot;
        logic [15:0] c;
        int unsigned key;
        int unsigned n;
        res.st = ST_NONE;
        res.po = '0;
        h = addr[8 +: HOST_BITS];
        slot = addr[31 -: SLOT_W];
        if (pr > PR_UDP || addr == '0)
        begin
            res.st = ST_INVALID;
        end
        else if (fn == FUNC_RELEASE)
        begin
            key = 32'({pr[0], prt, slot});
            if (port_taken.exists(key) && port_taken[key] == addr)
            begin
                port_taken.delete(key);
                res.st = ST_OK;
            end
        end
        else if (host_ip_tab[h] == addr || host_ip_tab[h] == '0)
        begin
            host_ip_tab[h] = addr;
            c = pr[0] ? udp_next[h] : tcp_next[h];
            for (n = 0; n < cfg_probe_limit; n++)
            begin
                c = c + 16'd1;
                if (c < cfg_first_port)
                    c = cfg_first_port;
                key = 32'({pr[0], c, slot});
                if (!port_taken.exists(key))
                begin
                    port_taken[key] = addr;
                    res.st = ST_OK;
                    res.po = c;
                    break;
                end
            end
            if (pr[0])
                udp_next[h] = c;
            else
                tcp_next[h] = c;
        end
        return res;
    endfunction

    // Drop start and hold until every expected result is back and the block is idle.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic sel, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_FIRST_PORT)
            cfg_first_port = val[15:0];
        else
            cfg_probe_limit = val[10:0];
    endtask

    // Present one request; return after the edge that accepts it. Start stays high.
    task automatic send_item(input logic fn, input logic [31:0] addr, input logic [15:0] prt,
                             input logic [1:0] pr, input logic chk, input logic [1:0] st,
                             input logic [15:0] po);
        result_t res;
        int found;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        func <= fn;
        ip <= addr;
        port <= prt;
        proto <= pr;
        do
            @(posedge clk);
        while (busy);
        res = pool_predict(fn, addr, prt, pr);
        if (fn == FUNC_ALLOC && res.st == ST_OK)
            held_ports.push_back('{pr: pr[0], prt: res.po, addr: addr});
        if (fn == FUNC_RELEASE && res.st == ST_OK)
        begin
            found = -1;
            for (int i = 0; i < held_ports.size(); i++)
                if (found < 0 && held_ports[i].pr == pr[0] && held_ports[i].prt == prt
                    && held_ports[i].addr == addr)
                    found = i;
            if (found >= 0)
                held_ports.delete(found);
        end
        if (chk)
        begin
            res.st = st;
            res.po = po;
        end
        pending_results.push_back(res);
    endtask

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d port_out %0d", status, port_out);
                fail_cnt = fail_cnt + 1;
            end
            else
            begin
                if (status !== pending_results[0].st)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           pending_results[0].st, status);
                    fail_cnt = fail_cnt + 1;
                end
                if (port_out !== pending_results[0].po)
                begin
                    $error("port_out mismatch: expected %0d, actual %0d",
                           pending_results[0].po, port_out);
                    fail_cnt = fail_cnt + 1;
                end
                void'(pending_results.pop_front());
            end
        end
        if (done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        row_t dir_tab[$];
        logic [31:0] seg_first [6];
        logic [31:0] seg_limit [6];
        logic [3:0] slot;
        logic [31:0] addr;
        logic [15:0] prt;
        logic [1:0] pr;
        logic fn;
        int r;
        int k;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        func = FUNC_ALLOC;
        ip = '0;
        port = '0;
        proto = PR_TCP;
        fail_cnt = 0;
        quiet_cycles = 0;
        idle_pct = 34;
        cfg_first_port = FIRST_PORT_RST;
        cfg_probe_limit = PROBE_LIMIT_RST;
        for (int i = 0; i < (1 << HOST_BITS); i++)
        begin
            host_ip_tab[i] = '0;
            tcp_next[i] = '0;
            udp_next[i] = '0;
        end

        dir_tab = '{
            chk_row(FUNC_ALLOC, 32'd0, 16'd0, PR_TCP, ST_INVALID, 16'd0),
            chk_row(FUNC_ALLOC, IP_A, 16'd0, 2'd2, ST_INVALID, 16'd0),
            chk_row(FUNC_RELEASE, IP_A, 16'hFFFF, 2'd3, ST_INVALID, 16'd0),
            chk_row(FUNC_RELEASE, 32'd0, 16'd1024, PR_TCP, ST_INVALID, 16'd0),
            chk_row(FUNC_ALLOC, IP_A, 16'hFFFF, PR_TCP, ST_OK, 16'd1024),
            chk_row(FUNC_ALLOC, IP_A, 16'd0, PR_TCP, ST_OK, 16'd1025),
            chk_row(FUNC_ALLOC, IP_A, 16'd0, PR_UDP, ST_OK, 16'd1024),
            chk_row(FUNC_ALLOC, IP_B, 16'd0, PR_TCP, ST_NONE, 16'd0),
            chk_row(FUNC_RELEASE, IP_B, 16'd1025, PR_TCP, ST_NONE, 16'd0),
            chk_row(FUNC_RELEASE, IP_A, 16'd1024, PR_TCP, ST_OK, 16'd0),
            chk_row(FUNC_RELEASE, IP_A, 16'd1024, PR_TCP, ST_NONE, 16'd0),
            item_row(FUNC_ALLOC, IP_A, 16'd0, PR_TCP),
            chk_row(FUNC_ALLOC, IP_MAX, 16'd0, PR_UDP, ST_OK, 16'd1024),
            chk_row(FUNC_RELEASE, IP_MAX, 16'd1024, PR_UDP, ST_OK, 16'd0),
            item_row(FUNC_ALLOC, IP_C, 16'h5A5A, PR_TCP),
            item_row(FUNC_RELEASE, 32'h8000_0000, 16'hFFFF, PR_UDP),
            cfg_row(REG_FIRST_PORT, 32'd65535),
            cfg_row(REG_PROBE_LIMIT, 32'd1),
            chk_row(FUNC_ALLOC, IP_A, 16'd0, PR_TCP, ST_OK, 16'd65535),
            chk_row(FUNC_ALLOC, IP_A, 16'd0, PR_TCP, ST_NONE, 16'd0),
            cfg_row(REG_PROBE_LIMIT, 32'd1024),
            chk_row(FUNC_ALLOC, IP_C, 16'd0, PR_TCP, ST_NONE, 16'd0),
            cfg_row(REG_FIRST_PORT, 32'd0),
            cfg_row(REG_PROBE_LIMIT, 32'd0),
            chk_row(FUNC_ALLOC, IP_D, 16'd0, PR_TCP, ST_NONE, 16'd0),
            chk_row(FUNC_ALLOC, IP_E, 16'd0, PR_TCP, ST_NONE, 16'd0),
            cfg_row(REG_PROBE_LIMIT, 32'd2),
            chk_row(FUNC_ALLOC, IP_A, 16'd0, PR_TCP, ST_OK, 16'd0),
            item_row(FUNC_ALLOC, IP_D, 16'd0, PR_TCP),
            chk_row(FUNC_RELEASE, IP_A, 16'd0, PR_TCP, ST_OK, 16'd0)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // hold through the clearing pass
        drain();

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].kind == ROW_CFG)
            begin
                drain();
                reg_write(dir_tab[i].reg_sel, dir_tab[i].reg_val);
            end
            else
                send_item(dir_tab[i].fn, dir_tab[i].addr, dir_tab[i].prt, dir_tab[i].pr,
                          dir_tab[i].chk, dir_tab[i].st, dir_tab[i].po);
        end

        // address pool: few hosts and slots so that owners collide
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            case ($urandom_range(2))
                0: slot = 4'h0;
                1: slot = 4'h1;
                default: slot = 4'hF;
            endcase
            host_pool[i] = {slot, 8'($urandom), 12'($urandom_range(15)), 8'($urandom) | 8'd1};
        end

        seg_first = '{32'd1024, 32'd65528, 32'd65520, 32'd0, 32'd49152,
                      32'($urandom_range(65500, 65535))};
        seg_limit = '{32'd256, 32'd4, 32'd16, 32'd1024, 32'd2047, 32'($urandom_range(1, 8))};

        for (int s = 0; s < 6; s++)
        begin
            idle_pct = (s < 2) ? 34 : (s < 4) ? 79 : 0;
            drain();
            reg_write(REG_FIRST_PORT, seg_first[s]);
            reg_write(REG_PROBE_LIMIT, seg_limit[s]);
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                r = $urandom_range(99);
                if (r >= 40 && r < 70 && held_ports.size() == 0)
                    r = 0;
                addr = host_pool[$urandom_range(POOL_SIZE - 1)];
                prt = 16'($urandom);
                pr = 2'($urandom_range(1));
                fn = FUNC_ALLOC;
                if (r >= 40 && r < 70)
                begin
                    k = $urandom_range(held_ports.size() - 1);
                    fn = FUNC_RELEASE;
                    addr = held_ports[k].addr;
                    prt = held_ports[k].prt;
                    pr = {1'b0, held_ports[k].pr};
                end
                else if (r >= 70 && r < 80)
                begin
                    // release by a possibly wrong owner
                    fn = FUNC_RELEASE;
                    if (held_ports.size() != 0 && r < 76)
                    begin
                        k = $urandom_range(held_ports.size() - 1);
                        prt = held_ports[k].prt;
                        pr = {1'b0, held_ports[k].pr};
                    end
                end
                else if (r >= 80 && r < 88)
                begin
                    fn = 1'($urandom_range(1));
                    if ($urandom_range(1))
                        addr = '0;
                    else
                        pr = 2'($urandom_range(2, 3));
                end
                else if (r >= 88)
                begin
                    fn = 1'($urandom_range(1));
                    addr = $urandom;
                    pr = 2'($urandom_range(3));
                end
                send_item(fn, addr, prt, pr, 1'b0, ST_OK, '0);
                if ($urandom_range(99) == 0)
                    drain();
            end
        end

        drain();
        repeat (16) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
